>>> hdl/assert_macros.svh
// Assertion helpers, empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_PROP(lbl, clk, rst, prop)
`endif

`endif

>>> hdl/rfps_pkg.sv
`default_nettype none

package rfps_pkg;

   // DEPTH must be a power of two
   localparam int DEPTH   = 256;
   localparam int DATA_W  = 16;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = 9;
   localparam int SKIP_W  = 9;
   localparam int KIND_W  = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH = 2'd0,
      KIND_POP  = 2'd1,
      KIND_PEEK = 2'd2,
      KIND_SKIP = 2'd3
   } rfps_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_FINISH
   } rfps_state_type;

   typedef struct packed {
      logic capture;
      logic access;
      logic load_out;
   } rfps_cmd_type;

   typedef struct packed {
      logic out_free;
   } rfps_sts_type;

endpackage

`default_nettype wire

>>> hdl/rfps_ram.sv
`default_nettype none

module rfps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/rfps_ctrl.sv
`default_nettype none

module rfps_ctrl
   import rfps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire rfps_sts_type sts,
   output rfps_cmd_type      cmd
);

   rfps_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/rfps_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module rfps_datapath
   import rfps_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rfps_cmd_type             cmd,
   output rfps_sts_type                  sts,
   input  wire logic [KIND_W-1:0]        req_kind,
   input  wire logic [DATA_W-1:0]        req_data_in,
   input  wire logic signed [IDX_W-1:0]  req_index,
   input  wire logic [SKIP_W-1:0]        req_skip_count,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_ok,
   output logic [DATA_W-1:0]             rsp_data_out,
   output logic [SKIP_W-1:0]             rsp_skipped,
   output logic [CNT_W-1:0]              rsp_fill_level
);

   localparam int EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
   localparam int CMP_W = (CNT_W > SKIP_W) ? CNT_W : SKIP_W;

   // captured item
   rfps_kind_type            kind_ff;
   logic [DATA_W-1:0]        data_ff;
   logic signed [IDX_W-1:0]  index_ff;
   logic [SKIP_W-1:0]        skip_ff;

   // ring state
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // staged result
   logic              res_ok_ff, res_ok_in;
   logic [SKIP_W-1:0] res_skip_ff, res_skip_in;
   logic              res_rd_ff, res_rd_in;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [SKIP_W-1:0] rsp_skipped_ff;
   logic [CNT_W-1:0]  rsp_fill_ff;

   logic                    full;
   logic                    empty;
   logic                    pushed;
   logic signed [EXT_W-1:0] idx_ext;
   logic [ADDR_W-1:0]       peek_pos;
   logic [CMP_W-1:0]        skip_ext;
   logic [CMP_W-1:0]        count_ext;
   logic [CNT_W-1:0]        skip_k;

   logic              ram_we;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   rfps_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head_ff),
      .wr_data (data_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // negative index counts back from the write position
   assign idx_ext  = EXT_W'(index_ff);
   assign peek_pos = (index_ff[IDX_W-1] ? head_ff : tail_ff) + idx_ext[ADDR_W-1:0];

   assign skip_ext  = CMP_W'(skip_ff);
   assign count_ext = CMP_W'(count_ff);
   assign skip_k    = (skip_ext < count_ext) ? CNT_W'(skip_ext) : count_ff;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      res_ok_in   = 1'b1;
      res_skip_in = '0;
      res_rd_in   = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = tail_ff;
      if (cmd.access) begin
         case (kind_ff)
            KIND_PUSH: begin
               if (full) begin
                  res_ok_in = 1'b0;
               end else begin
                  ram_we   = 1'b1;
                  head_in  = head_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            KIND_POP: begin
               if (empty) begin
                  res_ok_in = 1'b0;
               end else begin
                  ram_re    = 1'b1;
                  res_rd_in = 1'b1;
                  tail_in   = tail_ff + 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            KIND_PEEK: begin
               ram_re    = 1'b1;
               res_rd_in = 1'b1;
               ram_raddr = peek_pos;
            end
            default: begin
               tail_in     = tail_ff + ADDR_W'(skip_k);
               count_in    = count_ff - skip_k;
               res_skip_in = SKIP_W'(skip_k);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= rfps_kind_type'(req_kind);
         data_ff  <= req_data_in;
         index_ff <= req_index;
         skip_ff  <= req_skip_count;
      end
      if (cmd.access) begin
         res_ok_ff   <= res_ok_in;
         res_skip_ff <= res_skip_in;
         res_rd_ff   <= res_rd_in;
      end
      if (cmd.load_out) begin
         rsp_ok_ff      <= res_ok_ff;
         rsp_data_ff    <= res_rd_ff ? ram_rdata : '0;
         rsp_skipped_ff <= res_skip_ff;
         rsp_fill_ff    <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_skipped    = rsp_skipped_ff;
   assign rsp_fill_level = rsp_fill_ff;

   assign pushed = cmd.access && (kind_ff == KIND_PUSH) && !full;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `ASSERT_ALWAYS(a_ptr_count, clock, reset, ADDR_W'(head_ff - tail_ff) == count_ff[ADDR_W-1:0])
   `ASSERT_PROP(a_load_free, clock, reset, cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
   `ASSERT_PROP(a_push_count, clock, reset, pushed |=> (count_ff == $past(count_ff) + 1'b1))

endmodule

`default_nettype wire

>>> hdl/ring_fifo_with_peek_skip.sv
// Ring-buffer FIFO of DEPTH words (rfps_pkg, power of two) taking push, pop, peek and
// skip items, one result beat per item. An item goes from acceptance to its result beat
// through capture, storage access, then, once the result side is free, the registered
// read of the storage RAM lands in the output register. A stalled result holds the
// next item in its final state; the following item is accepted once the block is
// back in idle. Peeks past the stored entries return stale data.
`default_nettype none

module ring_fifo_with_peek_skip
   import rfps_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [KIND_W-1:0]        req_kind,
   input  wire logic [DATA_W-1:0]        req_data_in,
   input  wire logic signed [IDX_W-1:0]  req_index,
   input  wire logic [SKIP_W-1:0]        req_skip_count,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_ok,
   output logic [DATA_W-1:0]             rsp_data_out,
   output logic [SKIP_W-1:0]             rsp_skipped,
   output logic [CNT_W-1:0]              rsp_fill_level
);

   rfps_cmd_type cmd;
   rfps_sts_type sts;

   rfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfps_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_data_in    (req_data_in),
      .req_index      (req_index),
      .req_skip_count (req_skip_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_data_out   (rsp_data_out),
      .rsp_skipped    (rsp_skipped),
      .rsp_fill_level (rsp_fill_level)
   );

endmodule

`default_nettype wire
